// ===== src/spq_pkg.sv =====
// Package with shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_APPLY,
        ST_LOAD
    } state_t;

    // Commands that every cell of the array sees.
    typedef struct packed {
        logic compare;
        logic shift_ins;
        logic shift_rem;
    } cell_ctl_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        cell_ctl_t  ctl;
        logic       latch_op;
        logic       set_status;
        logic [1:0] status;
        logic       load_out;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic op_kind;
        logic full;
        logic hit;
        logic out_busy;
    } stat_t;

endpackage

// ===== src/spq_cell.sv =====
// One storage cell of the sorted array: compares with the operation key and shifts.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::cell_ctl_t                ctl,
    input  logic                              valid,
    input  logic signed [spq_pkg::KEY_W-1:0]  op_key,
    input  logic [spq_pkg::DATA_W-1:0]        op_data,
    input  logic                              left_lt_now,
    input  logic                              left_lt,
    input  logic signed [spq_pkg::KEY_W-1:0]  left_key,
    input  logic [spq_pkg::DATA_W-1:0]        left_data,
    input  logic signed [spq_pkg::KEY_W-1:0]  right_key,
    input  logic [spq_pkg::DATA_W-1:0]        right_data,
    output logic                              lt_now,
    output logic                              lt,
    output logic                              hit,
    output logic signed [spq_pkg::KEY_W-1:0]  key,
    output logic [spq_pkg::DATA_W-1:0]        data
);

    import spq_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic [DATA_W-1:0]       data_reg;
    logic [DATA_W-1:0]       data_next;
    logic                    lt_reg;
    logic                    hit_reg;
    logic                    eq_now;

    assign lt_now = valid && (key_reg < op_key);
    assign eq_now = valid && (key_reg == op_key);

    // Because the array is sorted, the first matching cell is the one whose
    // left neighbor is still smaller than the key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else if (ctl.compare)
        begin
            lt_reg  <= lt_now;
            hit_reg <= eq_now && left_lt_now;
        end
    end

    always_comb
    begin
        key_next  = key_reg;
        data_next = data_reg;
        if (ctl.shift_ins && !lt_reg)
        begin
            if (left_lt)
            begin
                key_next  = op_key;
                data_next = op_data;
            end
            else
            begin
                key_next  = left_key;
                data_next = left_data;
            end
        end
        else if (ctl.shift_rem && !lt_reg)
        begin
            key_next  = right_key;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign lt   = lt_reg;
    assign hit  = hit_reg;
    assign key  = key_reg;
    assign data = data_reg;

endmodule

// ===== src/spq_datapath.sv =====
// Datapath: operation registers, cell array, occupancy and the result register.
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spq_pkg::cmd_t                       cmd,
    output spq_pkg::stat_t                      stat,
    input  logic                                in_kind,
    input  logic [spq_pkg::KEY_W-1:0]           in_key,
    input  logic [spq_pkg::DATA_W-1:0]          in_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [1:0]                          out_status,
    output logic [spq_pkg::COUNT_W-1:0]         out_count,
    output logic                                out_head_valid,
    output logic [spq_pkg::KEY_W-1:0]           out_head_key,
    output logic [spq_pkg::DATA_W-1:0]          out_head_data
);

    import spq_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

    logic                    kind_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [DATA_W-1:0]       data_reg;
    logic [OCC_W-1:0]        occ_reg;
    logic [OCC_W-1:0]        occ_next;
    logic [1:0]              status_reg;

    logic                    out_valid_reg;
    logic [1:0]              out_status_reg;
    logic [COUNT_W-1:0]      out_count_reg;
    logic                    out_head_valid_reg;
    logic [KEY_W-1:0]        out_head_key_reg;
    logic [DATA_W-1:0]       out_head_data_reg;

    logic signed [KEY_W-1:0] cell_key  [CAPACITY];
    logic [DATA_W-1:0]       cell_data [CAPACITY];
    logic [CAPACITY-1:0]     cell_lt_now;
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     cell_hit;
    logic [EXT_W-1:0]        occ_ext;
    logic                    empty;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_op)
        begin
            kind_reg <= in_kind;
            key_reg  <= $signed(in_key);
            data_reg <= in_data;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                    valid;
            logic                    left_lt_now;
            logic                    left_lt;
            logic signed [KEY_W-1:0] left_key;
            logic [DATA_W-1:0]       left_data;
            logic signed [KEY_W-1:0] right_key;
            logic [DATA_W-1:0]       right_data;

            assign valid = occ_reg > OCC_W'(i);

            if (i == 0)
            begin : g_head
                assign left_lt_now = 1'b1;
                assign left_lt     = 1'b1;
                assign left_key    = key_reg;
                assign left_data   = data_reg;
            end
            else
            begin : g_body
                assign left_lt_now = cell_lt_now[i-1];
                assign left_lt     = cell_lt[i-1];
                assign left_key    = cell_key[i-1];
                assign left_data   = cell_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_key  = cell_key[i];
                assign right_data = cell_data[i];
            end
            else
            begin : g_inner
                assign right_key  = cell_key[i+1];
                assign right_data = cell_data[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (cmd.ctl),
                .valid       (valid),
                .op_key      (key_reg),
                .op_data     (data_reg),
                .left_lt_now (left_lt_now),
                .left_lt     (left_lt),
                .left_key    (left_key),
                .left_data   (left_data),
                .right_key   (right_key),
                .right_data  (right_data),
                .lt_now      (cell_lt_now[i]),
                .lt          (cell_lt[i]),
                .hit         (cell_hit[i]),
                .key         (cell_key[i]),
                .data        (cell_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.ctl.shift_ins)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (cmd.ctl.shift_rem)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
    end

    assign occ_ext = EXT_W'(occ_reg);
    assign empty   = (occ_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg     <= status_reg;
            out_count_reg      <= occ_ext[COUNT_W-1:0];
            out_head_valid_reg <= !empty;
            out_head_key_reg   <= empty ? '0 : cell_key[0];
            out_head_data_reg  <= empty ? '0 : cell_data[0];
        end
    end

    assign stat.op_kind  = kind_reg;
    assign stat.full     = (occ_reg == OCC_W'(CAPACITY));
    assign stat.hit      = |cell_hit;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_count      = out_count_reg;
    assign out_head_valid = out_head_valid_reg;
    assign out_head_key   = out_head_key_reg;
    assign out_head_data  = out_head_data_reg;

endmodule

// ===== src/spq_controller.sv =====
// Controller state machine that sequences accept, compare, update and result.
`timescale 1ns / 1ps

module spq_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output spq_pkg::cmd_t   cmd,
    input  spq_pkg::stat_t  stat
);

    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_op = 1'b1;
                    state_next   = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.ctl.compare = 1'b1;
                state_next      = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.set_status = 1'b1;
                if (stat.op_kind == KIND_INSERT)
                begin
                    if (stat.full)
                    begin
                        cmd.status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.status        = STATUS_DONE;
                        cmd.ctl.shift_ins = 1'b1;
                    end
                end
                else
                begin
                    if (stat.hit)
                    begin
                        cmd.status        = STATUS_DONE;
                        cmd.ctl.shift_rem = 1'b1;
                    end
                    else
                    begin
                        cmd.status = STATUS_MISS;
                    end
                end
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue with stream ports.
`timescale 1ns / 1ps

// The queue keeps up to CAPACITY entries, each a signed 32-bit key with a
// 32-bit data handle, in ascending key order in a row of cells, so the head
// (smallest key) is always in the first cell. An insert beat (tuser = 0)
// places the entry ahead of every stored entry with an equal or greater key,
// so equal keys leave newest first; a remove beat (tuser = 1) deletes the
// first entry from the head whose key matches. Every input beat yields one
// output beat with the status, the entry count (modulo 32) and the head
// entry after the operation; head fields read zero when the queue is empty.
// An insert into a full queue returns status 1 and a remove that finds
// nothing returns status 2, both leaving the contents unchanged. Each beat
// goes through four steps: accept, a broadcast compare in all cells at once,
// the shift of the cell row, and the load of the output register, which waits
// while an earlier result is not yet taken. The next beat is accepted while a
// result still waits in the output register. Stored entries need no clearing
// after reset; the entry count alone says which cells hold data.
module sorted_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key [31:0], data_handle [63:32]
    input  logic        s_tuser,   // kind [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // status [1:0], entry_count [6:2], head_valid [7],
                                   // head_key [39:8], head_data [71:40]
);

    import spq_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [1:0]         out_status;
    logic [COUNT_W-1:0] out_count;
    logic               out_head_valid;
    logic [KEY_W-1:0]   out_head_key;
    logic [DATA_W-1:0]  out_head_data;

    spq_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_kind        (s_tuser),
        .in_key         (s_tdata[31:0]),
        .in_data        (s_tdata[63:32]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_status     (out_status),
        .out_count      (out_count),
        .out_head_valid (out_head_valid),
        .out_head_key   (out_head_key),
        .out_head_data  (out_head_data)
    );

    // Result fields packed from the lowest bit up.
    assign m_tdata = {out_head_data, out_head_key, out_head_valid, out_count, out_status};

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the sorted priority queue: directed table, random traffic.
`timescale 1ns / 1ps

module tb_top;

    import spq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int RAND_OPS    = 1000;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // One result beat, unpacked into its fields.
    typedef struct packed {
        logic [1:0]                status;
        logic [COUNT_W-1:0]        entry_count;
        logic                      head_valid;
        logic signed [KEY_W-1:0]   head_key;
        logic [DATA_W-1:0]         head_data;
    } queue_result_t;

    // One row of the directed table; the typed result is used when has_typed is set.
    typedef struct {
        logic                    kind;
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       data;
        bit                      has_typed;
        queue_result_t           typed;
    } op_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    // Shadow copy of the queue contents, kept in ascending key order.
    logic signed [KEY_W-1:0] shadow_key [CAPACITY];
    logic [DATA_W-1:0]       shadow_data [CAPACITY];
    int                      shadow_count = 0;

    queue_result_t pending_results[$];
    op_row_t       directed_ops[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            sender_quiet = 1'b0;

    sorted_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Applies one operation to the shadow queue and returns the result it produces.
    function automatic queue_result_t apply_queue_op(input logic kind,
                                                     input logic signed [KEY_W-1:0] key,
                                                     input logic [DATA_W-1:0] data);
        queue_result_t res;
        int            pos;
        res = '0;
        pos = 0;
        if (kind == KIND_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                res.status = STATUS_FULL;
            end
            else begin
                // New entry goes ahead of every equal key.
                while (pos < shadow_count && shadow_key[pos] < key)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_key[i]  = shadow_key[i-1];
                    shadow_data[i] = shadow_data[i-1];
                end
                shadow_key[pos]  = key;
                shadow_data[pos] = data;
                shadow_count++;
                res.status = STATUS_DONE;
            end
        end
        else begin
            while (pos < shadow_count && shadow_key[pos] != key)
                pos++;
            if (pos >= shadow_count) begin
                res.status = STATUS_MISS;
            end
            else begin
                for (int i = pos; i + 1 < shadow_count; i++) begin
                    shadow_key[i]  = shadow_key[i+1];
                    shadow_data[i] = shadow_data[i+1];
                end
                shadow_count--;
                res.status = STATUS_DONE;
            end
        end
        res.entry_count = shadow_count[COUNT_W-1:0];
        if (shadow_count > 0) begin
            res.head_valid = 1'b1;
            res.head_key   = shadow_key[0];
            res.head_data  = shadow_data[0];
        end
        return res;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (sender_quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    function automatic void add_row(input logic kind, input logic signed [KEY_W-1:0] key,
                                    input logic [DATA_W-1:0] data, input bit has_typed,
                                    input queue_result_t typed);
        op_row_t row;
        row.kind      = kind;
        row.key       = key;
        row.data      = data;
        row.has_typed = has_typed;
        row.typed     = typed;
        directed_ops.push_back(row);
    endfunction

    // Presents one beat from a falling edge, waits for its acceptance and
    // records the expected result; returns at the next falling edge.
    task automatic send_op(input logic kind, input logic signed [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] data, input bit has_typed,
                           input queue_result_t typed);
        queue_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {data, key};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_queue_op(kind, key, data);
        pending_results.push_back(has_typed ? typed : predicted);
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Receiver side: stretches of steady readiness alternate with random stalls.
    initial begin
        int  stretch;
        int  r;
        int  stall;
        bit  steady;
        wait (rst_n);
        forever begin
            stretch = $urandom_range(10, 60);
            steady  = ($urandom_range(0, 3) == 0);
            repeat (stretch) begin
                @(negedge clk);
                if (steady) begin
                    m_tready <= 1'b1;
                end
                else begin
                    r = $urandom_range(0, 99);
                    if (r < 5) begin
                        m_tready <= 1'b0;
                        stall = $urandom_range(4, 20);
                        repeat (stall - 1) @(negedge clk);
                    end
                    else begin
                        m_tready <= (r < 65);
                    end
                end
            end
        end
    end

    // Result checker: every accepted beat is matched against the oldest expectation.
    always @(posedge clk) begin
        queue_result_t got;
        queue_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status      = m_tdata[1:0];
            got.entry_count = m_tdata[6:2];
            got.head_valid  = m_tdata[7];
            got.head_key    = m_tdata[39:8];
            got.head_data   = m_tdata[71:40];
            if (pending_results.size() == 0) begin
                if (error_count < REPORT_MAX)
                    $display("unexpected result beat: status %0d count %0d head %0b %0d %h",
                             got.status, got.entry_count, got.head_valid,
                             got.head_key, got.head_data);
                error_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.entry_count !== want.entry_count
                    || got.head_valid !== want.head_valid || got.head_key !== want.head_key
                    || got.head_data !== want.head_data) begin
                    if (error_count < REPORT_MAX) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected: status %0d count %0d head %0b %0d %h",
                                 want.status, want.entry_count, want.head_valid,
                                 want.head_key, want.head_data);
                        $display("  actual:   status %0d count %0d head %0b %0d %h",
                                 got.status, got.entry_count, got.head_valid,
                                 got.head_key, got.head_data);
                    end
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic                    kind;
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       data;
        int                      insert_bias;
        int                      r;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Remove on an empty queue, then the key extremes.
        add_row(KIND_REMOVE, 32'sd0, 32'h0000_0000, 1'b1,
                '{STATUS_MISS, 5'd0, 1'b0, 32'sd0, 32'h0});
        add_row(KIND_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                '{STATUS_DONE, 5'd1, 1'b1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF});
        add_row(KIND_INSERT, 32'sh8000_0000, 32'h0000_0000, 1'b1,
                '{STATUS_DONE, 5'd2, 1'b1, 32'sh8000_0000, 32'h0});
        // An equal key goes ahead, and a remove takes the newest of the equals.
        add_row(KIND_INSERT, 32'sh8000_0000, 32'h0000_0001, 1'b0, '0);
        add_row(KIND_REMOVE, 32'sh8000_0000, 32'h5555_5555, 1'b0, '0);
        add_row(KIND_REMOVE, 32'sd12345, 32'hAAAA_AAAA, 1'b0, '0);
        // Fill the queue to capacity with mixed signs and duplicates.
        add_row(KIND_INSERT, -32'sd1, 32'h1111_1111, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd0, 32'h2222_2222, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd1, 32'h3333_3333, 1'b0, '0);
        add_row(KIND_INSERT, -32'sd5, 32'h4444_4444, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd100, 32'h5555_5555, 1'b0, '0);
        add_row(KIND_INSERT, -32'sd100, 32'h6666_6666, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd7, 32'h7777_7777, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd7, 32'h8888_8888, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd3, 32'h9999_9999, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd2, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(KIND_INSERT, -32'sd2, 32'hBBBB_BBBB, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd1000, 32'hCCCC_CCCC, 1'b0, '0);
        add_row(KIND_INSERT, -32'sd1000, 32'hDDDD_DDDD, 1'b0, '0);
        add_row(KIND_INSERT, 32'sd42, 32'hEEEE_EEEE, 1'b0, '0);
        // Insert into a full queue leaves everything as it was.
        add_row(KIND_INSERT, 32'sd9, 32'h1234_5678, 1'b1,
                '{STATUS_FULL, 5'd16, 1'b1, 32'sh8000_0000, 32'h0});
        // Remove at the tail, at the head and in the middle.
        add_row(KIND_REMOVE, 32'sh7FFF_FFFF, 32'h0000_0000, 1'b0, '0);
        add_row(KIND_REMOVE, 32'sh8000_0000, 32'h0000_0000, 1'b0, '0);
        add_row(KIND_REMOVE, 32'sd7, 32'hFFFF_FFFF, 1'b0, '0);

        foreach (directed_ops[i]) begin
            send_op(directed_ops[i].kind, directed_ops[i].key, directed_ops[i].data,
                    directed_ops[i].has_typed, directed_ops[i].typed);
            idle_sender(gap_length());
        end

        // Hold off until everything has come out before the random part.
        wait_for_drain();

        insert_bias = 50;
        for (int n = 0; n < RAND_OPS; n++) begin
            // Phases that lean toward inserts or removes drive the queue
            // between empty and full.
            if (n % 40 == 0) begin
                r = $urandom_range(0, 2);
                insert_bias  = (r == 0) ? 85 : (r == 1) ? 15 : 50;
                sender_quiet = ($urandom_range(0, 4) == 0);
            end
            if (n == RAND_OPS / 2)
                wait_for_drain();

            kind = ($urandom_range(0, 99) < insert_bias) ? KIND_INSERT : KIND_REMOVE;
            data = $urandom;
            r    = $urandom_range(0, 99);
            if (kind == KIND_REMOVE && shadow_count > 0 && r < 80) begin
                key = shadow_key[$urandom_range(0, shadow_count - 1)];
            end
            else if (r < 40) begin
                key = int'($urandom_range(0, 15)) - 8;
            end
            else if (r < 60 && shadow_count > 0) begin
                key = shadow_key[$urandom_range(0, shadow_count - 1)];
            end
            else if (r < 80) begin
                case ($urandom_range(0, 3))
                    0:       key = 32'sh8000_0000;
                    1:       key = 32'sh7FFF_FFFF;
                    2:       key = -32'sd1;
                    default: key = 32'sd0;
                endcase
            end
            else begin
                key = $urandom;
            end

            send_op(kind, key, data, 1'b0, '0);
            idle_sender(gap_length());
        end

        wait_for_drain();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
